[rtl/core/kli_pkg.sv]
// Shared types and constants for the keyframe linear interpolator.
package kli_pkg;

  localparam int KEY_INDEX_W = 6;
  localparam int KEY_COUNT_W = 7;
  localparam int TIME_W      = 32;
  localparam int VAL_W       = 32;
  localparam int DIFF_W      = VAL_W + 1;
  localparam int FRAC_W      = 16;
  localparam int T_W         = FRAC_W + 1;
  localparam int PROD_W      = DIFF_W + T_W;
  localparam int NUM_COMP    = 3;
  localparam int COMP_W      = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Codes of the input kind field
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic [KEY_INDEX_W-1:0]   key_index;
    logic [TIME_W-1:0]        key_time;
    logic signed [VAL_W-1:0]  key_x;
    logic signed [VAL_W-1:0]  key_y;
    logic signed [VAL_W-1:0]  key_z;
    logic [TIME_W-1:0]        query_time;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] out_x;
    logic signed [VAL_W-1:0] out_y;
    logic signed [VAL_W-1:0] out_z;
  } out_item_t;

  // Operation classes handed from the front end to the back end
  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_FIRST,
    CMD_SCAN
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t                  op;
    logic [KEY_INDEX_W-1:0]   key_index;
    logic [TIME_W-1:0]        stamp;
    logic signed [VAL_W-1:0]  val_x;
    logic signed [VAL_W-1:0]  val_y;
    logic signed [VAL_W-1:0]  val_z;
    logic [KEY_COUNT_W-1:0]   last_key;
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] off;
  } div_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T0,
    ST_SCAN,
    ST_VA,
    ST_VB,
    ST_DIV,
    ST_MUL,
    ST_ONE,
    ST_OUT
  } back_state_t;

endpackage

[rtl/core/keyframe_linear_interpolator_unit.sv]
// Top level of the keyframe piecewise linear interpolator.
//
//   channel  ports                           transfer when
//   input    in_valid  in_stall  in_data     in_valid && !in_stall
//   result   out_valid out_stall out_data    out_valid && !out_stall
//   config   cfg_valid cfg_ready cfg_data    cfg_valid && cfg_ready
//
// A load writes the key table from the back-end idle state. A query answered by key 0
// reads the first key; one that lands in segment k is found by the scan, which reads one
// key time per cycle from the table port, and takes its fraction from the 16-step serial
// divider; a time past every segment returns the last key in use. Synchronous active-low
// reset clears control state; the key table is not cleared. A two-entry queue lets input
// transactions keep arriving while the result register waits on out_stall.
module keyframe_linear_interpolator_unit #(
  parameter int MAX_KEYS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  kli_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output kli_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kli_pkg::KEY_COUNT_W-1:0]   cfg_data
);
  import kli_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_cmd;

  kli_front #(
    .MAX_KEYS (MAX_KEYS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .cmd       (push_cmd)
  );

  kli_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_cmd)
  );

  kli_back #(
    .MAX_KEYS (MAX_KEYS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/core/kli_div.sv]
// Bit-serial divider forming the 16-bit segment fraction off * 65536 / span.
module kli_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  kli_pkg::div_req_t          req,
  output logic                       busy,
  output logic [kli_pkg::T_W-1:0]    quotient
);
  import kli_pkg::*;

  localparam int CNT_W = $clog2(FRAC_W + 1);

  logic [TIME_W-1:0] rem_r, rem_nxt;
  logic [TIME_W-1:0] span_r, span_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic              int_r, int_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [TIME_W:0]   shifted;
  logic              ge;

  // One quotient bit per cycle, restoring form
  always_comb begin
    shifted  = {rem_r, 1'b0};
    ge       = (shifted >= {1'b0, span_r});
    rem_nxt  = rem_r;
    span_nxt = span_r;
    frac_nxt = frac_r;
    int_nxt  = int_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (req.start) begin
      span_nxt = req.span;
      frac_nxt = '0;
      if (req.span == '0) begin
        // zero-length segment yields a zero fraction
        int_nxt  = 1'b0;
        rem_nxt  = '0;
        cnt_nxt  = '0;
        busy_nxt = 1'b0;
      end else begin
        // off never exceeds span, so the integer bit is set only when equal
        int_nxt  = (req.off == req.span);
        rem_nxt  = (req.off == req.span) ? '0 : req.off;
        cnt_nxt  = CNT_W'(FRAC_W);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt  = ge ? TIME_W'(shifted - {1'b0, span_r}) : TIME_W'(shifted);
      frac_nxt = {frac_r[FRAC_W-2:0], ge};
      cnt_nxt  = cnt_r - CNT_W'(1);
      busy_nxt = (cnt_r != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    span_r <= span_nxt;
    frac_r <= frac_nxt;
    int_r  <= int_nxt;
  end

  assign busy     = busy_r;
  assign quotient = {int_r, frac_r};

endmodule

[rtl/core/kli_front.sv]
// Front end: accepts input transactions, holds the key count, classifies items.
module kli_front #(
  parameter int MAX_KEYS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  kli_pkg::in_item_t                 in_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kli_pkg::KEY_COUNT_W-1:0]   cfg_data,
  input  logic                              q_full,
  output logic                              push,
  output kli_pkg::cmd_t                     cmd
);
  import kli_pkg::*;

  logic [KEY_COUNT_W-1:0] key_count_r, key_count_nxt;
  logic                   accept;
  logic                   idx_ok;

  // Configuration register, always ready
  assign cfg_ready     = 1'b1;
  assign key_count_nxt = (cfg_valid && cfg_ready) ? cfg_data : key_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= KEY_COUNT_W'(1);
    end else begin
      key_count_r <= key_count_nxt;
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign idx_ok   = (32'(in_data.key_index) < MAX_KEYS);

  // Classify: drop out-of-range loads, clamp the key count for queries
  always_comb begin
    cmd.key_index = in_data.key_index;
    cmd.val_x     = in_data.key_x;
    cmd.val_y     = in_data.key_y;
    cmd.val_z     = in_data.key_z;
    cmd.stamp     = in_data.query_time;
    cmd.last_key  = '0;
    cmd.op        = CMD_LOAD;
    push          = 1'b0;
    if (in_data.kind == KIND_LOAD) begin
      cmd.op    = CMD_LOAD;
      cmd.stamp = in_data.key_time;
      push      = accept && idx_ok;
    end else begin
      push = accept;
      if (key_count_r <= KEY_COUNT_W'(1)) begin
        cmd.op = CMD_FIRST;
      end else if (32'(key_count_r) > MAX_KEYS) begin
        cmd.op       = CMD_SCAN;
        cmd.last_key = KEY_COUNT_W'(MAX_KEYS - 1);
      end else begin
        cmd.op       = CMD_SCAN;
        cmd.last_key = key_count_r - KEY_COUNT_W'(1);
      end
    end
  end

endmodule

[rtl/core/kli_queue.sv]
// Short command queue between the front end and the back end.
module kli_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  kli_pkg::cmd_t  push_data,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output kli_pkg::cmd_t  pop_data
);
  import kli_pkg::*;

  cmd_t              slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = slots_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/core/kli_back.sv]
// Back end: key table, segment scan, fraction divide, interpolation, result register.
module kli_back #(
  parameter int MAX_KEYS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  kli_pkg::cmd_t      q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output kli_pkg::out_item_t out_data
);
  import kli_pkg::*;

  localparam int IDX_W = $clog2(MAX_KEYS);

  // Key table
  logic [TIME_W-1:0] time_mem [MAX_KEYS];
  logic [VAL_W-1:0]  x_mem    [MAX_KEYS];
  logic [VAL_W-1:0]  y_mem    [MAX_KEYS];
  logic [VAL_W-1:0]  z_mem    [MAX_KEYS];

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [IDX_W-1:0]  raddr, raddr_r;
  logic [TIME_W-1:0] rd_time_r;
  logic [VAL_W-1:0]  rd_val_r [NUM_COMP];

  back_state_t       state_r, state_nxt;
  logic [TIME_W-1:0] q_r, q_nxt;
  logic [TIME_W-1:0] prev_r, prev_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [IDX_W-1:0]  last_r, last_nxt;
  logic [COMP_W-1:0] cnt_r, cnt_nxt;
  logic [VAL_W-1:0]  a_r   [NUM_COMP];
  logic [VAL_W-1:0]  a_nxt [NUM_COMP];
  logic [DIFF_W-1:0] d_r   [NUM_COMP];
  logic [DIFF_W-1:0] d_nxt [NUM_COMP];
  logic [VAL_W-1:0]  res_r   [NUM_COMP];
  logic [VAL_W-1:0]  res_nxt [NUM_COMP];
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [PROD_W-1:0] d_ext, t_ext;

  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic              out_free;

  div_req_t          div_req;
  logic              div_busy;
  logic [T_W-1:0]    t_frac;

  kli_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .busy     (div_busy),
    .quotient (t_frac)
  );

  // Table write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      time_mem[waddr] <= q_data.stamp;
      x_mem[waddr]    <= q_data.val_x;
      y_mem[waddr]    <= q_data.val_y;
      z_mem[waddr]    <= q_data.val_z;
    end
    rd_time_r   <= time_mem[raddr];
    rd_val_r[0] <= x_mem[raddr];
    rd_val_r[1] <= y_mem[raddr];
    rd_val_r[2] <= z_mem[raddr];
  end

  assign out_free = !out_valid_r || !out_stall;
  assign d_ext    = {{(PROD_W - DIFF_W){d_r[cnt_r][DIFF_W-1]}}, d_r[cnt_r]};
  assign t_ext    = {{(PROD_W - T_W){1'b0}}, t_frac};

  // Next state and datapath control
  always_comb begin
    state_nxt    = state_r;
    q_pop        = 1'b0;
    we           = 1'b0;
    waddr        = IDX_W'(q_data.key_index);
    raddr        = raddr_r;
    q_nxt        = q_r;
    prev_nxt     = prev_r;
    k_nxt        = k_r;
    last_nxt     = last_r;
    cnt_nxt      = cnt_r;
    a_nxt        = a_r;
    d_nxt        = d_r;
    res_nxt      = res_r;
    prod_nxt     = prod_r;
    div_req      = '0;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_data.op)
            CMD_LOAD: begin
              we = 1'b1;
            end
            CMD_FIRST: begin
              raddr     = '0;
              state_nxt = ST_ONE;
            end
            CMD_SCAN: begin
              raddr     = '0;
              q_nxt     = q_data.stamp;
              last_nxt  = IDX_W'(q_data.last_key);
              state_nxt = ST_T0;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_T0: begin
        if (q_r <= rd_time_r) begin
          raddr     = '0;
          state_nxt = ST_ONE;
        end else begin
          prev_nxt  = rd_time_r;
          k_nxt     = IDX_W'(1);
          raddr     = IDX_W'(1);
          state_nxt = ST_SCAN;
        end
      end

      // Walk one segment per cycle; the upper key time is on the read port
      ST_SCAN: begin
        if (q_r >= prev_r && q_r <= rd_time_r) begin
          div_req.start = 1'b1;
          div_req.span  = rd_time_r - prev_r;
          div_req.off   = q_r - prev_r;
          raddr         = k_r - IDX_W'(1);
          state_nxt     = ST_VA;
        end else if (k_r == last_r) begin
          raddr     = k_r;
          state_nxt = ST_ONE;
        end else begin
          prev_nxt  = rd_time_r;
          k_nxt     = k_r + IDX_W'(1);
          raddr     = k_r + IDX_W'(1);
          state_nxt = ST_SCAN;
        end
      end

      ST_VA: begin
        for (int c = 0; c < NUM_COMP; c++) begin
          a_nxt[c] = rd_val_r[c];
        end
        raddr     = k_r;
        state_nxt = ST_VB;
      end

      ST_VB: begin
        for (int c = 0; c < NUM_COMP; c++) begin
          d_nxt[c] = {rd_val_r[c][VAL_W-1], rd_val_r[c]} - {a_r[c][VAL_W-1], a_r[c]};
        end
        state_nxt = ST_DIV;
      end

      ST_DIV: begin
        if (!div_busy) begin
          cnt_nxt   = '0;
          state_nxt = ST_MUL;
        end
      end

      // Share one multiplier over the three components; each add follows in the next cycle
      ST_MUL: begin
        if (cnt_r != COMP_W'(NUM_COMP)) begin
          prod_nxt = $signed(d_ext * t_ext);
        end
        if (cnt_r != '0) begin
          res_nxt[cnt_r - COMP_W'(1)] = a_r[cnt_r - COMP_W'(1)] + prod_r[FRAC_W+VAL_W-1:FRAC_W];
        end
        if (cnt_r == COMP_W'(NUM_COMP)) begin
          state_nxt = ST_OUT;
        end else begin
          cnt_nxt = cnt_r + COMP_W'(1);
        end
      end

      ST_ONE: begin
        for (int c = 0; c < NUM_COMP; c++) begin
          res_nxt[c] = rd_val_r[c];
        end
        state_nxt = ST_OUT;
      end

      // Hold until the result register is free
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_data_nxt.out_x = res_r[0];
          out_data_nxt.out_y = res_r[1];
          out_data_nxt.out_z = res_r[2];
          state_nxt          = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      raddr_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      raddr_r     <= raddr;
    end
  end

  always_ff @(posedge clk) begin
    q_r        <= q_nxt;
    prev_r     <= prev_nxt;
    k_r        <= k_nxt;
    last_r     <= last_nxt;
    cnt_r      <= cnt_nxt;
    a_r        <= a_nxt;
    d_r        <= d_nxt;
    res_r      <= res_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
